// ===== src/tape_machine_executor_defines.svh =====
// ----------------------------------------------------------------------------
// tape machine executor assertion macros
// concurrent checks clocked on clock and disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef TAPE_MACHINE_EXECUTOR_DEFINES_SVH
`define TAPE_MACHINE_EXECUTOR_DEFINES_SVH

// same-cycle implication
`define TME_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tme: same-cycle check failed");

// next-cycle implication
`define TME_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tme: next-cycle check failed");

// invariant
`define TME_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("tme: invariant failed");

`endif

// ===== src/tme_pkg.sv =====
// ----------------------------------------------------------------------------
// tme_pkg
// opcodes, result kinds, controller states and the command and status
// bundles shared by the tape machine executor modules
// ----------------------------------------------------------------------------
package tme_pkg;

   localparam int AmountW    = 16;
   localparam int ReqDataW   = 64;
   localparam int RspDataW   = 32;

   // reset value of the tape size register
   localparam int TapeSizeReset = 32768;

   // step reduction walks the 16 magnitude bits from the top down
   localparam logic [3:0] RED_TOP = 4'd15;

   // opcodes; invalid, fork and unused codes fall to the default arm
   localparam logic [3:0] OP_ADD   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_SET   = 4'd3;
   localparam logic [3:0] OP_SCAN  = 4'd4;
   localparam logic [3:0] OP_MOVE  = 4'd5;
   localparam logic [3:0] OP_JZ    = 4'd6;
   localparam logic [3:0] OP_JNZ   = 4'd7;
   localparam logic [3:0] OP_IO    = 4'd8;
   localparam logic [3:0] OP_DEBUG = 4'd10;
   localparam logic [3:0] OP_HALT  = 4'd11;

   typedef enum logic [2:0] {
      RES_NEXT,
      RES_JUMP,
      RES_HOLD,
      RES_HALT,
      RES_BAD,
      RES_OUT
   } res_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_REDUCE,
      ST_FIX,
      ST_MADDR,
      ST_MWRITE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic    accept;
      logic    clr_step;
      logic    cell_wr;
      logic    mul_load;
      logic    mul_wr;
      logic    ptr_move;
      logic    rd_next;
      logic    red_step;
      logic    red_fix;
      logic    scan_step;
      logic    finish;
      res_type res;
   } cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       io_write;
      logic       cell_zero;
      logic       step_ok;
      logic       red_last;
      logic       scan_full;
      logic       rsp_free;
      logic       clr_last;
   } sts_type;

endpackage

// ===== src/tme_ctrl.sv =====
// ----------------------------------------------------------------------------
// tme_ctrl
// sequencer for the tape machine executor: tape clear after reset, item
// accept, execute, step reduction, multiply read-modify-write and scan loop
// ----------------------------------------------------------------------------
module tme_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tme_pkg::sts_type  sts,
   output tme_pkg::cmd_type  cmd
);

   tme_pkg::state_type state_ff;
   tme_pkg::state_type state_in;

   logic             fin;
   logic             fin_wr;
   logic             fin_move;
   logic             fin_mul_wr;
   tme_pkg::res_type fin_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tme_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.res    = tme_pkg::RES_NEXT;
      req_tready = 1'b0;
      fin        = 1'b0;
      fin_wr     = 1'b0;
      fin_move   = 1'b0;
      fin_mul_wr = 1'b0;
      fin_res    = tme_pkg::RES_NEXT;

      unique case (state_ff)
         tme_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = tme_pkg::ST_IDLE;
            end
         end
         tme_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = tme_pkg::ST_EXEC;
            end
         end
         tme_pkg::ST_EXEC: begin
            unique case (sts.op) inside
               tme_pkg::OP_ADD, tme_pkg::OP_SET: begin
                  fin    = 1'b1;
                  fin_wr = 1'b1;
               end
               tme_pkg::OP_IO: begin
                  fin = 1'b1;
                  if (sts.io_write) begin
                     fin_res = tme_pkg::RES_OUT;
                  end else begin
                     fin_wr = 1'b1;
                  end
               end
               tme_pkg::OP_JZ: begin
                  fin     = 1'b1;
                  fin_res = sts.cell_zero ? tme_pkg::RES_JUMP : tme_pkg::RES_NEXT;
               end
               tme_pkg::OP_JNZ: begin
                  fin     = 1'b1;
                  fin_res = sts.cell_zero ? tme_pkg::RES_NEXT : tme_pkg::RES_JUMP;
               end
               tme_pkg::OP_DEBUG: begin
                  fin = 1'b1;
               end
               tme_pkg::OP_HALT: begin
                  fin     = 1'b1;
                  fin_res = tme_pkg::RES_HALT;
               end
               tme_pkg::OP_MOVE: begin
                  if (sts.step_ok) begin
                     fin      = 1'b1;
                     fin_move = 1'b1;
                  end else begin
                     state_in = tme_pkg::ST_REDUCE;
                  end
               end
               tme_pkg::OP_MUL: begin
                  if (sts.cell_zero) begin
                     fin = 1'b1;
                  end else if (sts.step_ok) begin
                     state_in = tme_pkg::ST_MADDR;
                  end else begin
                     state_in = tme_pkg::ST_REDUCE;
                  end
               end
               tme_pkg::OP_SCAN: begin
                  state_in = sts.step_ok ? tme_pkg::ST_SCAN : tme_pkg::ST_REDUCE;
               end
               default: begin
                  fin     = 1'b1;
                  fin_res = tme_pkg::RES_BAD;
               end
            endcase
         end
         tme_pkg::ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (sts.red_last) begin
               state_in = tme_pkg::ST_FIX;
            end
         end
         tme_pkg::ST_FIX: begin
            cmd.red_fix = 1'b1;
            state_in    = tme_pkg::ST_EXEC;
         end
         tme_pkg::ST_MADDR: begin
            // target cell read issued here, product registered alongside
            cmd.mul_load = 1'b1;
            cmd.rd_next  = 1'b1;
            state_in     = tme_pkg::ST_MWRITE;
         end
         tme_pkg::ST_MWRITE: begin
            // keep the target cell on the read port while the write waits
            cmd.rd_next = 1'b1;
            fin         = 1'b1;
            fin_mul_wr  = 1'b1;
         end
         tme_pkg::ST_SCAN: begin
            if (sts.cell_zero || sts.scan_full) begin
               fin     = 1'b1;
               fin_res = sts.cell_zero ? tme_pkg::RES_NEXT : tme_pkg::RES_HOLD;
            end else begin
               cmd.ptr_move  = 1'b1;
               cmd.rd_next   = 1'b1;
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = tme_pkg::ST_CLEAR;
         end
      endcase

      // final tape write and result load wait for room in the output register
      if (fin && sts.rsp_free) begin
         cmd.finish   = 1'b1;
         cmd.res      = fin_res;
         cmd.cell_wr  = fin_wr;
         cmd.mul_wr   = fin_mul_wr;
         cmd.ptr_move = cmd.ptr_move | fin_move;
         state_in     = tme_pkg::ST_IDLE;
      end
   end

endmodule

// ===== src/tme_datapath.sv =====
// ----------------------------------------------------------------------------
// tme_datapath
// tape memory, tape pointer, program counter, tape size register, step
// reduction unit, scan counter and the result register
// ----------------------------------------------------------------------------
module tme_datapath #(
   parameter int TAPE_DEPTH     = 32768,
   parameter int CODE_ADDR_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [15:0]                    csr_wr_data,
   input  logic [tme_pkg::ReqDataW-1:0]   req_tdata,
   input  tme_pkg::cmd_type               cmd,
   output tme_pkg::sts_type               sts,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [tme_pkg::RspDataW-1:0]   rsp_tdata
);

   localparam int PW  = $clog2(TAPE_DEPTH);
   localparam int SZW = $clog2(TAPE_DEPTH + 1);
   localparam int CW  = (PW + 1 > tme_pkg::AmountW + 1) ? PW + 1 : tme_pkg::AmountW + 1;
   localparam int RW  = SZW + tme_pkg::AmountW;
   localparam logic [31:0]    Depth32   = 32'(TAPE_DEPTH);
   localparam logic [SZW-1:0] SizeReset =
      SZW'((TAPE_DEPTH < tme_pkg::TapeSizeReset) ? TAPE_DEPTH : tme_pkg::TapeSizeReset);
   localparam logic [PW-1:0]  ClrLast   = PW'(TAPE_DEPTH - 1);

   // request fields
   logic [3:0]         req_mode;
   logic signed [15:0] req_amount;
   logic [15:0]        amt_raw;
   logic [15:0]        amt_mag;
   logic               amt_fast;

   // instruction registers
   logic [3:0]         op_ff;
   logic signed [15:0] amount_ff;
   logic [7:0]         factor_ff;
   logic [7:0]         imm_ff;
   logic               io_write_ff;
   logic [15:0]        target_ff;
   logic [7:0]         in_byte_ff;
   logic               in_eof_ff;

   // architectural state
   logic [PW-1:0]             ptr_ff;
   logic [CODE_ADDR_BITS-1:0] pc_ff;
   logic [SZW-1:0]            size_ff;

   // working registers
   logic [PW-1:0]      step_ff;
   logic               step_ok_ff;
   logic [15:0]        rem_ff;
   logic [3:0]         k_ff;
   logic [SZW-1:0]     cnt_ff;
   logic [PW-1:0]      clr_cnt_ff;
   logic [PW-1:0]      tgt_ff;
   logic [7:0]         prod_ff;

   // tape memory
   logic [7:0]         tape_mem [TAPE_DEPTH];
   logic [7:0]         rd_data_ff;
   logic [PW-1:0]      rd_addr;
   logic               wr_en;
   logic [PW-1:0]      wr_addr;
   logic [7:0]         wr_data;
   logic [7:0]         cell_val;

   logic [PW:0]        ptr_sum;
   logic [PW:0]        size_w;
   logic [PW-1:0]      ptr_step;
   logic [RW-1:0]      red_sub;
   logic [31:0]        csr_clamp;

   // result register
   logic                      rsp_valid_ff;
   logic [tme_pkg::RspDataW-1:0] rsp_data_ff;
   logic [CODE_ADDR_BITS-1:0] pc_in;
   logic                      res_out;

   assign req_mode   = req_tdata[3:0];
   assign req_amount = $signed(req_tdata[19:4]);
   assign amt_raw    = req_tdata[19:4];
   assign amt_mag    = req_amount[15] ? (~amt_raw + 16'd1) : amt_raw;
   assign amt_fast   = CW'(amt_mag) < CW'(size_ff);

   // pointer plus reduced step, wrapped once at the tape size
   assign size_w   = (PW + 1)'(size_ff);
   assign ptr_sum  = (PW + 1)'(ptr_ff) + (PW + 1)'(step_ff);
   assign ptr_step = (ptr_sum >= size_w) ? PW'(ptr_sum - size_w) : PW'(ptr_sum);

   assign red_sub = RW'(size_ff) << k_ff;

   always_comb begin
      csr_clamp = 32'(csr_wr_data);
      if (csr_clamp == 32'd0) begin
         csr_clamp = 32'd1;
      end
      if (csr_clamp > Depth32) begin
         csr_clamp = Depth32;
      end
   end

   // instruction capture and step preparation
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_mode;
         amount_ff   <= req_amount;
         factor_ff   <= req_tdata[27:20];
         imm_ff      <= req_tdata[35:28];
         io_write_ff <= req_tdata[36];
         target_ff   <= req_tdata[52:37];
         in_byte_ff  <= req_tdata[60:53];
         in_eof_ff   <= req_tdata[61];
         step_ff     <= PW'(req_amount[15] ? CW'(size_ff) - CW'(amt_mag) : CW'(amt_mag));
         step_ok_ff  <= amt_fast;
         rem_ff      <= amt_mag;
         k_ff        <= tme_pkg::RED_TOP;
         cnt_ff      <= '0;
      end else begin
         if (cmd.red_step) begin
            if (RW'(rem_ff) >= red_sub) begin
               rem_ff <= rem_ff - 16'(red_sub);
            end
            k_ff <= k_ff - 4'd1;
         end
         if (cmd.red_fix) begin
            step_ff    <= PW'((amount_ff[15] && (rem_ff != 16'd0)) ?
                              CW'(size_ff) - CW'(rem_ff) : CW'(rem_ff));
            step_ok_ff <= 1'b1;
         end
         if (cmd.scan_step) begin
            cnt_ff <= cnt_ff + SZW'(1);
         end
      end
      if (cmd.mul_load) begin
         tgt_ff  <= ptr_step;
         prod_ff <= 8'(rd_data_ff * factor_ff);
      end
   end

   // pointer and tape size
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         size_ff <= SizeReset;
      end else if (csr_wr_en) begin
         size_ff <= SZW'(csr_clamp);
         if (32'(ptr_ff) >= csr_clamp) begin
            ptr_ff <= '0;
         end
      end else if (cmd.ptr_move) begin
         ptr_ff <= ptr_step;
      end
   end

   // clear sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + PW'(1);
      end
   end

   always_comb begin
      unique case (op_ff)
         tme_pkg::OP_ADD: cell_val = rd_data_ff + amount_ff[7:0];
         tme_pkg::OP_SET: cell_val = imm_ff;
         default:         cell_val = in_eof_ff ? 8'd0 : in_byte_ff;
      endcase
   end

   assign rd_addr = cmd.rd_next ? ptr_step : ptr_ff;
   assign wr_en   = cmd.clr_step | cmd.cell_wr | cmd.mul_wr;

   always_comb begin
      if (cmd.clr_step) begin
         wr_addr = clr_cnt_ff;
         wr_data = 8'd0;
      end else if (cmd.mul_wr) begin
         wr_addr = tgt_ff;
         wr_data = rd_data_ff + prod_ff;
      end else begin
         wr_addr = ptr_ff;
         wr_data = cell_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tape_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= tape_mem[rd_addr];
   end

   // program counter and result
   always_comb begin
      unique case (cmd.res) inside
         tme_pkg::RES_NEXT, tme_pkg::RES_OUT: pc_in = pc_ff + CODE_ADDR_BITS'(1);
         tme_pkg::RES_JUMP:                   pc_in = CODE_ADDR_BITS'(target_ff);
         default:                             pc_in = pc_ff;
      endcase
   end

   assign res_out = (cmd.res == tme_pkg::RES_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {5'd0,
                         (cmd.res == tme_pkg::RES_BAD),
                         (cmd.res == tme_pkg::RES_HALT),
                         (res_out ? rd_data_ff : 8'd0),
                         res_out,
                         16'(pc_in)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sts.op        = op_ff;
   assign sts.io_write  = io_write_ff;
   assign sts.cell_zero = (rd_data_ff == 8'd0);
   assign sts.step_ok   = step_ok_ff;
   assign sts.red_last  = (k_ff == 4'd0);
   assign sts.scan_full = (cnt_ff == size_ff);
   assign sts.rsp_free  = ~rsp_valid_ff | rsp_tready;
   assign sts.clr_last  = (clr_cnt_ff == ClrLast);

endmodule

// ===== src/tape_machine_executor.sv =====
// ----------------------------------------------------------------------------
// tape_machine_executor
// executes one tape machine instruction per request item, one result each
// ----------------------------------------------------------------------------
// req channel carries the instruction at the current program counter plus an
// input byte; rsp channel returns next_pc, output byte and stop flags. the
// csr port writes the tape size (clamped to 1..TAPE_DEPTH); the user must
// write it only while idle, which the block itself does not enforce.
// after reset the tape is swept to zero one cell a cycle: req_tready stays
// low until every cell is cleared, csr writes are taken throughout.
// one item is worked at a time. add, set, io, jumps, debug, halt, invalid,
// move and mul on a zero cell finish in execute; mul on a nonzero cell then
// reads the target cell and writes it back; scan moves cell by cell until it
// reads a zero or has made size steps. when |amount| is not below the tape
// size the step is first reduced by a bit-serial remainder unit. the tape is
// a single-port-write, registered-read memory. the result sits in an output
// register, so a stalled rsp side holds one result while the next item is
// accepted; that item then waits at its final step until the register frees.
// ----------------------------------------------------------------------------
`include "tape_machine_executor_defines.svh"

module tape_machine_executor #(
   parameter int TAPE_DEPTH     = 32768,
   parameter int CODE_ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // tape size register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // mode[3:0], amount[19:4], factor[27:20], immediate[35:28], io_write[36],
   // target[52:37], in_byte[60:53], in_eof[61], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // next_pc[15:0], out_valid[16], out_byte[24:17], halted[25], bad_op[26],
   // zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata
);

   tme_pkg::cmd_type cmd;
   tme_pkg::sts_type sts;

   tme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tme_datapath #(
      .TAPE_DEPTH     (TAPE_DEPTH),
      .CODE_ADDR_BITS (CODE_ADDR_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

   `TME_ASSERT_IMPLIES(a_finish_room, cmd.finish, sts.rsp_free)
   `TME_ASSERT_ALWAYS(a_one_writer, $onehot0({cmd.clr_step, cmd.cell_wr, cmd.mul_wr}))
   `TME_ASSERT_NEXT(a_one_at_a_time, cmd.accept, !req_tready)
   `TME_ASSERT_NEXT(a_result_loaded, cmd.finish, rsp_tvalid)

endmodule
